>>> src/ucfd_pkg.sv
`default_nettype none

package ucfd_pkg;

    // command codes
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_CHECK   = 1'b1;

    // frame opcodes
    localparam logic [7:0] OP_TIME_SYNC = 8'd2;
    localparam logic [7:0] OP_SET_ALARM = 8'd4;
    localparam logic [7:0] OP_NONE      = 8'd0;

    // framing bytes
    localparam logic [7:0] MARK_BYTE = 8'hFF;
    localparam logic [7:0] END_BYTE  = 8'h0D;

    localparam logic [7:0] HOURS_HALF    = 8'd12;
    localparam int         NUM_PARAMS    = 3;
    localparam logic [1:0] PARAM_FULL    = 2'd3;
    localparam logic [2:0] TRACK_DEFAULT = 3'd4;

    // v mod 12: fold 16*h + l to 4*h + l (at most 75), then reciprocal multiply
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [6:0]  x;
        logic [12:0] prod;
        logic [2:0]  q;
        logic [6:0]  r;
        x    = 7'({v[7:4], 2'b00}) + 7'(v[3:0]);
        prod = 13'(x) * 13'd43;
        q    = prod[11:9];
        r    = x - 7'(q) * 7'd12;
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

>>> src/uart_command_frame_decoder.sv
`default_nettype none

// channel   valid        ready        payload
// input     i_in_valid   o_in_ready   i_command, i_rx_byte, i_clock_hour, i_clock_minute,
//                                     i_clock_pm
// output    o_out_valid  i_out_ready  o_frame_done ... o_alarm_fire (twelve fields)
//
// one request per cycle while the output is not stalled: the whole per-byte update is
// done in the accept cycle and the result lands in the single output register in the next cycle
// a new request is taken while the output register is empty or being drained
// when the output stalls, o_in_ready drops and the frame and alarm state hold
// synchronous active-low reset clears frame state, alarm state and the output valid

module uart_command_frame_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_command,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [3:0] i_clock_hour,
    input  wire logic [5:0] i_clock_minute,
    input  wire logic       i_clock_pm,

    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_frame_done,
    output logic            o_time_set_valid,
    output logic [3:0]      o_set_hour,
    output logic            o_set_pm,
    output logic [7:0]      o_set_minute,
    output logic [7:0]      o_set_second,
    output logic [2:0]      o_track_index,
    output logic [3:0]      o_alarm_hour_out,
    output logic [7:0]      o_alarm_minute_out,
    output logic            o_alarm_pm_out,
    output logic            o_alarm_armed_out,
    output logic            o_alarm_fire
);

    // frame state
    logic       r_frame_open, n_frame_open;
    logic [7:0] r_prev_byte,  n_prev_byte;
    logic [7:0] r_opcode,     n_opcode;
    logic [1:0] r_param_count, n_param_count;
    logic [7:0] r_param [ucfd_pkg::NUM_PARAMS];
    logic [7:0] n_param [ucfd_pkg::NUM_PARAMS];

    // alarm state
    logic [3:0] r_alarm_hour,   n_alarm_hour;
    logic [7:0] r_alarm_minute, n_alarm_minute;
    logic       r_alarm_pm,     n_alarm_pm;
    logic       r_alarm_armed,  n_alarm_armed;
    logic [2:0] r_track,        n_track;

    // output register
    logic       r_out_valid;
    logic       r_frame_done,   n_frame_done;
    logic       r_time_set,     n_time_set;
    logic [3:0] r_set_hour,     n_set_hour;
    logic       r_set_pm,       n_set_pm;
    logic [7:0] r_set_minute,   n_set_minute;
    logic [7:0] r_set_second,   n_set_second;
    logic       r_fire,         n_fire;

    logic accept;

    // byte decode terms
    logic       is_mark;
    logic       prev_mark;
    logic       open_frame;
    logic       take_opcode;
    logic       in_param;
    logic       close_frame;
    logic       clock_differs;
    logic       clock_matches;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;

    // output register frees up when empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_mark     = (i_rx_byte == ucfd_pkg::MARK_BYTE);
    assign prev_mark   = (r_prev_byte == ucfd_pkg::MARK_BYTE);
    // two marks in a row open a frame
    assign open_frame  = prev_mark && is_mark && !r_frame_open;
    // first non-mark after a mark inside an open frame with no opcode yet
    assign take_opcode = !is_mark && prev_mark && (r_opcode == ucfd_pkg::OP_NONE)
                         && r_frame_open;
    // any other received byte inside an open frame is a parameter byte
    assign in_param    = (i_command == ucfd_pkg::CMD_RX_BYTE) && r_frame_open
                         && !take_opcode;
    // raw carriage return closes, even when it was not stored
    assign close_frame = in_param && (i_rx_byte == ucfd_pkg::END_BYTE);

    // parameters stored inverted; the closing byte also goes into the next free slot when there is room
    always_comb begin
        for (int k = 0; k < ucfd_pkg::NUM_PARAMS; k++) begin
            if (in_param && (r_param_count == 2'(k))) begin
                n_param[k] = ~i_rx_byte;
            end else begin
                n_param[k] = r_param[k];
            end
        end
    end

    assign p0 = n_param[0];
    assign p1 = n_param[1];
    assign p2 = n_param[2];

    assign clock_differs = (r_alarm_minute != {2'b00, i_clock_minute})
                           || (r_alarm_hour != i_clock_hour)
                           || (r_alarm_pm != i_clock_pm);
    assign clock_matches = !clock_differs;

    // next state and next result for the current request
    always_comb begin
        n_frame_open   = r_frame_open;
        n_prev_byte    = r_prev_byte;
        n_opcode       = r_opcode;
        n_param_count  = r_param_count;
        n_alarm_hour   = r_alarm_hour;
        n_alarm_minute = r_alarm_minute;
        n_alarm_pm     = r_alarm_pm;
        n_alarm_armed  = r_alarm_armed;
        n_track        = r_track;
        n_frame_done   = 1'b0;
        n_time_set     = 1'b0;
        n_set_hour     = 4'd0;
        n_set_pm       = 1'b0;
        n_set_minute   = 8'd0;
        n_set_second   = 8'd0;
        n_fire         = 1'b0;

        if (i_command == ucfd_pkg::CMD_CHECK) begin
            // alarm check leaves the frame state alone
            if (r_alarm_armed && clock_matches) begin
                n_alarm_armed = 1'b0;
                n_fire        = 1'b1;
            end
        end else begin
            n_prev_byte = i_rx_byte;
            if (open_frame) begin
                n_frame_open = 1'b1;
            end else if (take_opcode) begin
                n_opcode = i_rx_byte;
            end else if (in_param) begin
                // count saturates once all parameter slots are filled
                if (r_param_count != ucfd_pkg::PARAM_FULL) begin
                    n_param_count = r_param_count + 2'd1;
                end
                if (close_frame) begin
                    n_frame_done = 1'b1;
                    if (r_opcode == ucfd_pkg::OP_TIME_SYNC) begin
                        n_time_set   = 1'b1;
                        n_set_hour   = ucfd_pkg::mod12(p0);
                        n_set_pm     = (p0 >= ucfd_pkg::HOURS_HALF);
                        n_set_minute = p1;
                        n_set_second = p2;
                    end else if (r_opcode == ucfd_pkg::OP_SET_ALARM) begin
                        // tracks 1..4 map to 0..3, anything else to the default track
                        if ((p2 >= 8'd1) && (p2 <= 8'd4)) begin
                            n_track = 3'(p2 - 8'd1);
                        end else begin
                            n_track = ucfd_pkg::TRACK_DEFAULT;
                        end
                        // reload only when the stored alarm is not the current time
                        if (clock_differs) begin
                            n_alarm_hour   = ucfd_pkg::mod12(p0);
                            n_alarm_pm     = (p0 >= ucfd_pkg::HOURS_HALF);
                            n_alarm_minute = p1;
                            n_alarm_armed  = 1'b1;
                        end
                    end
                    // frame close drops opcode, count and frame flag
                    n_opcode      = ucfd_pkg::OP_NONE;
                    n_param_count = 2'd0;
                    n_frame_open  = 1'b0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open   <= 1'b0;
            r_prev_byte    <= 8'd0;
            r_opcode       <= ucfd_pkg::OP_NONE;
            r_param_count  <= 2'd0;
            r_alarm_hour   <= 4'd0;
            r_alarm_minute <= 8'd0;
            r_alarm_pm     <= 1'b0;
            r_alarm_armed  <= 1'b0;
            r_track        <= 3'd0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < ucfd_pkg::NUM_PARAMS; k++) begin
                r_param[k] <= 8'd0;
            end
        end else begin
            if (accept) begin
                r_frame_open   <= n_frame_open;
                r_prev_byte    <= n_prev_byte;
                r_opcode       <= n_opcode;
                r_param_count  <= n_param_count;
                r_alarm_hour   <= n_alarm_hour;
                r_alarm_minute <= n_alarm_minute;
                r_alarm_pm     <= n_alarm_pm;
                r_alarm_armed  <= n_alarm_armed;
                r_track        <= n_track;
                // parameter slots read as zero again after a close
                for (int k = 0; k < ucfd_pkg::NUM_PARAMS; k++) begin
                    r_param[k] <= (i_command == ucfd_pkg::CMD_RX_BYTE && close_frame)
                                  ? 8'd0 : n_param[k];
                end
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_frame_done <= n_frame_done;
            r_time_set   <= n_time_set;
            r_set_hour   <= n_set_hour;
            r_set_pm     <= n_set_pm;
            r_set_minute <= n_set_minute;
            r_set_second <= n_set_second;
            r_fire       <= n_fire;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_done       = r_frame_done;
    assign o_time_set_valid   = r_time_set;
    assign o_set_hour         = r_set_hour;
    assign o_set_pm           = r_set_pm;
    assign o_set_minute       = r_set_minute;
    assign o_set_second       = r_set_second;
    // alarm and track fields show the state left by the request just delivered
    assign o_track_index      = r_track;
    assign o_alarm_hour_out   = r_alarm_hour;
    assign o_alarm_minute_out = r_alarm_minute;
    assign o_alarm_pm_out     = r_alarm_pm;
    assign o_alarm_armed_out  = r_alarm_armed;
    assign o_alarm_fire       = r_fire;

`ifndef SYNTHESIS
    // no opcode or parameter survives outside an open frame
    a_closed_frame_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_open |-> (r_opcode == ucfd_pkg::OP_NONE) && (r_param_count == 2'd0))
        else $error("frame state left over outside a frame");

    // a time setting is only reported on a closing byte, with an hour below 12
    a_time_set_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_set_valid |-> o_frame_done && (o_set_hour < 4'd12))
        else $error("time setting without frame close or hour out of range");

    // firing always disarms and never comes with a frame close
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alarm_fire |-> !o_alarm_armed_out && !o_frame_done)
        else $error("alarm fired but still armed");

    // a full output register that is not drained blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while result stalled");

    // state holds when no request is taken
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_alarm_armed) && $stable(r_prev_byte) && $stable(r_track))
        else $error("state changed without a request");
`endif

endmodule

`default_nettype wire
